@@ hw/rtl/pspm_pkg.sv @@
// ----------------------------------------------------------------------------
// pspm_pkg
// Shared types and constants for the palette scanline pixel mapper.
// ----------------------------------------------------------------------------
package pspm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GREYSCALE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCANLINE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 3'd4;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Reset values of the size registers
  localparam logic [8:0] ACTIVE_WIDTH_RST  = 9'd256;
  localparam logic [7:0] ACTIVE_HEIGHT_RST = 8'd224;

  // Luminance weights, sum is 256
  localparam logic [7:0] GREY_WR = 8'd77;
  localparam logic [7:0] GREY_WG = 8'd150;
  localparam logic [7:0] GREY_WB = 8'd29;

  typedef struct packed {
    logic        op;
    logic [7:0]  entry_index;
    logic [23:0] entry_color;
    logic [7:0]  line;
    logic [8:0]  column;
    logic [7:0]  pixel_index;
  } req_t;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic        blanked;
  } rsp_t;

  typedef struct packed {
    logic       greyscale_on;
    logic       scanline_blank_on;
    logic       source_present;
    logic [8:0] active_width;
    logic [7:0] active_height;
  } cfg_t;

endpackage

@@ hw/rtl/pspm_palette.sv @@
// ----------------------------------------------------------------------------
// pspm_palette
// Palette RAM with one write and one registered read port. Per-entry valid
// bits make unwritten entries read as black after reset.
// ----------------------------------------------------------------------------
module pspm_palette #(
  parameter int ENTRIES = 256,
  parameter int IDX_W   = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [23:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [23:0]      rd_color
);

  logic [23:0]        mem [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [23:0]        rd_data;
  logic               rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= entry_valid[rd_addr];
      end
    end
  end

  assign rd_color = rd_hit ? rd_data : 24'd0;

  a_reset_clears: assert property (@(posedge clk) rst |=> (entry_valid == '0))
    else $error("palette valid bits not cleared by reset");

  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> entry_valid[$past(wr_addr)])
    else $error("written palette entry not marked valid");

endmodule

@@ hw/rtl/pspm_window.sv @@
// ----------------------------------------------------------------------------
// pspm_window
// Decides whether a pixel falls inside the active picture and is not
// blanked by source absence or the scanline effect.
// ----------------------------------------------------------------------------
module pspm_window #(
  parameter int LOGICAL_WIDTH = 320,
  parameter int LOGICAL_LINES = 240,
  parameter int LEFT_BORDER   = 32,
  parameter int TOP_BORDER    = 8
) (
  input  pspm_pkg::cfg_t cfg,
  input  logic [7:0]     line,
  input  logic [8:0]     column,
  output logic           visible
);

  localparam int ROOM = (LOGICAL_WIDTH > LEFT_BORDER) ? LOGICAL_WIDTH - LEFT_BORDER : 0;

  logic [11:0] line_x;
  logic [11:0] col_x;
  logic [11:0] width_x;
  logic [11:0] eff_width;
  logic [11:0] top_end;
  logic [11:0] left_end;

  always_comb begin
    line_x    = {4'd0, line};
    col_x     = {3'd0, column};
    width_x   = {3'd0, cfg.active_width};
    // active width saturates at the columns right of the border
    eff_width = (width_x > 12'(ROOM)) ? 12'(ROOM) : width_x;
    top_end   = 12'(TOP_BORDER) + {4'd0, cfg.active_height};
    left_end  = 12'(LEFT_BORDER) + eff_width;
    visible   = (line_x < 12'(LOGICAL_LINES)) && (col_x < 12'(LOGICAL_WIDTH)) &&
                (line_x >= 12'(TOP_BORDER)) && (line_x < top_end) &&
                (col_x >= 12'(LEFT_BORDER)) && (col_x < left_end) &&
                cfg.source_present && !(cfg.scanline_blank_on && line[0]);
  end

endmodule

@@ hw/rtl/pspm_color.sv @@
// ----------------------------------------------------------------------------
// pspm_color
// Optional luminance conversion of a 0xRRGGBB color and RGB565 packing.
// ----------------------------------------------------------------------------
module pspm_color (
  input  logic [23:0] color,
  input  logic        greyscale_on,
  output logic [15:0] rgb565
);

  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;
  logic [15:0] pr;
  logic [15:0] pg;
  logic [15:0] pb;
  logic [15:0] luma_sum;
  logic [7:0]  y;
  logic [7:0]  ro;
  logic [7:0]  go;
  logic [7:0]  bo;

  always_comb begin
    r        = color[23:16];
    g        = color[15:8];
    b        = color[7:0];
    pr       = {8'd0, r} * {8'd0, pspm_pkg::GREY_WR};
    pg       = {8'd0, g} * {8'd0, pspm_pkg::GREY_WG};
    pb       = {8'd0, b} * {8'd0, pspm_pkg::GREY_WB};
    // weights sum to 256, so the total stays within 16 bits
    luma_sum = pr + pg + pb;
    y        = luma_sum[15:8];
    ro       = greyscale_on ? y : r;
    go       = greyscale_on ? y : g;
    bo       = greyscale_on ? y : b;
    rgb565   = {ro[7:3], go[7:2], bo[7:3]};
  end

endmodule

@@ hw/rtl/palette_scanline_pixel_mapper.sv @@
// ----------------------------------------------------------------------------
// palette_scanline_pixel_mapper
// Pipeline: an accepted pixel passes through the lookup stage and then the result register.
// Throughput: one item per cycle while req_stall is low; palette writes give no result.
// The output register holds one stalled result while one more item waits
// in the lookup stage behind the palette RAM read port.
// Reset clears the config registers to their defaults and all palette
// valid bits at once, so every entry reads black until written.
// ----------------------------------------------------------------------------
module palette_scanline_pixel_mapper #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int LOGICAL_WIDTH   = 320,
  parameter int LOGICAL_LINES   = 240,
  parameter int LEFT_BORDER     = 32,
  parameter int TOP_BORDER      = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  pspm_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output pspm_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pspm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pspm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  pspm_pkg::cfg_t cfg;
  logic           accept;
  logic           pix_accept;
  logic           wr_accept;
  logic           out_free;
  logic           visible;
  logic           s1_valid;
  logic           s1_visible;
  logic           s1_in_range;
  logic [23:0]    rd_color;
  logic [23:0]    lookup_color;
  logic [15:0]    packed_color;

  assign cfg_ready  = 1'b1;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign req_stall  = s1_valid && !out_free;
  assign accept     = req_valid && !req_stall;
  assign pix_accept = accept && (req.op == pspm_pkg::OP_PIXEL);
  assign wr_accept  = accept && (req.op == pspm_pkg::OP_WRITE) &&
                      ({1'b0, req.entry_index} < 9'(PALETTE_ENTRIES));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.greyscale_on      <= 1'b0;
      cfg.scanline_blank_on <= 1'b0;
      cfg.source_present    <= 1'b0;
      cfg.active_width      <= pspm_pkg::ACTIVE_WIDTH_RST;
      cfg.active_height     <= pspm_pkg::ACTIVE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pspm_pkg::CFG_GREYSCALE:     cfg.greyscale_on      <= cfg_data[0];
        pspm_pkg::CFG_SCANLINE:      cfg.scanline_blank_on <= cfg_data[0];
        pspm_pkg::CFG_SOURCE:        cfg.source_present    <= cfg_data[0];
        pspm_pkg::CFG_ACTIVE_WIDTH:  cfg.active_width      <= cfg_data[8:0];
        pspm_pkg::CFG_ACTIVE_HEIGHT: cfg.active_height     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  pspm_window #(
    .LOGICAL_WIDTH (LOGICAL_WIDTH),
    .LOGICAL_LINES (LOGICAL_LINES),
    .LEFT_BORDER   (LEFT_BORDER),
    .TOP_BORDER    (TOP_BORDER)
  ) u_window (
    .cfg     (cfg),
    .line    (req.line),
    .column  (req.column),
    .visible (visible)
  );

  pspm_palette #(
    .ENTRIES (PALETTE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_palette (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_accept),
    .wr_addr  (req.entry_index[IDX_W-1:0]),
    .wr_data  (req.entry_color),
    .rd_en    (pix_accept),
    .rd_addr  (req.pixel_index[IDX_W-1:0]),
    .rd_color (rd_color)
  );

  // lookup stage, aligned with the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= pix_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_visible  <= visible;
      s1_in_range <= {1'b0, req.pixel_index} < 9'(PALETTE_ENTRIES);
    end
  end

  assign lookup_color = s1_in_range ? rd_color : 24'd0;

  pspm_color u_color (
    .color        (lookup_color),
    .greyscale_on (cfg.greyscale_on),
    .rgb565       (packed_color)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      rsp.pixel_rgb565 <= s1_visible ? packed_color : 16'd0;
      rsp.blanked      <= !s1_visible;
    end
  end

  a_blank_is_black: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.blanked) |-> (rsp.pixel_rgb565 == 16'd0))
    else $error("blanked pixel carries a color");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && rsp_valid && rsp_stall) |-> req_stall)
    else $error("transfer taken with both stages full");

  a_pixel_enters: assert property (@(posedge clk) disable iff (rst)
    pix_accept |=> s1_valid)
    else $error("accepted pixel lost before lookup stage");

endmodule

@@ tb/sv/pixel_color_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_color_checker
// Watches the config, request and result channels of the pixel mapper. Keeps
// its own palette and register copy, computes the RGB565 value of every
// accepted pixel and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module pixel_color_checker #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int LOGICAL_WIDTH   = 320,
  parameter int LOGICAL_LINES   = 240,
  parameter int LEFT_BORDER     = 32,
  parameter int TOP_BORDER      = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  pspm_pkg::req_t                  req,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  pspm_pkg::rsp_t                  rsp,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pspm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pspm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              checked
);

  logic [23:0]    palette_copy [PALETTE_ENTRIES];
  pspm_pkg::cfg_t regs;
  pspm_pkg::rsp_t expected_pixels [$];

  function automatic logic [23:0] luma_grey(logic [23:0] c);
    logic [17:0] y;
    y = 18'(c[23:16]) * 18'(pspm_pkg::GREY_WR) +
        18'(c[15:8])  * 18'(pspm_pkg::GREY_WG) +
        18'(c[7:0])   * 18'(pspm_pkg::GREY_WB);
    return {3{y[15:8]}};
  endfunction

  function automatic pspm_pkg::rsp_t predict_pixel(pspm_pkg::req_t r);
    int             ln;
    int             col;
    int             w;
    int             room;
    logic           shown;
    logic [23:0]    c;
    pspm_pkg::rsp_t o;
    ln   = int'(r.line);
    col  = int'(r.column);
    room = (LOGICAL_WIDTH > LEFT_BORDER) ? LOGICAL_WIDTH - LEFT_BORDER : 0;
    w    = int'(regs.active_width);
    if (w > room) w = room;
    shown = (ln < LOGICAL_LINES) && (col < LOGICAL_WIDTH) &&
            (ln >= TOP_BORDER) && (ln - TOP_BORDER < int'(regs.active_height)) &&
            (col >= LEFT_BORDER) && (col - LEFT_BORDER < w) &&
            regs.source_present && !(regs.scanline_blank_on && r.line[0]);
    if (!shown) begin
      o.pixel_rgb565 = 16'h0000;
      o.blanked      = 1'b1;
      return o;
    end
    c = (int'(r.pixel_index) < PALETTE_ENTRIES) ? palette_copy[r.pixel_index] : 24'h0;
    if (regs.greyscale_on) c = luma_grey(c);
    o.pixel_rgb565 = {c[23:19], c[15:10], c[7:3]};
    o.blanked      = 1'b0;
    return o;
  endfunction

  always @(posedge clk) begin
    pspm_pkg::rsp_t want;
    if (rst) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) palette_copy[i] = 24'h0;
      regs.greyscale_on      = 1'b0;
      regs.scanline_blank_on = 1'b0;
      regs.source_present    = 1'b0;
      regs.active_width      = pspm_pkg::ACTIVE_WIDTH_RST;
      regs.active_height     = pspm_pkg::ACTIVE_HEIGHT_RST;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pspm_pkg::CFG_GREYSCALE:     regs.greyscale_on      = cfg_data[0];
          pspm_pkg::CFG_SCANLINE:      regs.scanline_blank_on = cfg_data[0];
          pspm_pkg::CFG_SOURCE:        regs.source_present    = cfg_data[0];
          pspm_pkg::CFG_ACTIVE_WIDTH:  regs.active_width      = cfg_data[8:0];
          pspm_pkg::CFG_ACTIVE_HEIGHT: regs.active_height     = cfg_data[7:0];
          default: ;
        endcase
      end
      // compare first, so a pixel taken at this edge never answers an early result
      if (rsp_valid && !rsp_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: rgb565 %h blanked %b",
                     rsp.pixel_rgb565, rsp.blanked);
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (rsp.pixel_rgb565 !== want.pixel_rgb565 || rsp.blanked !== want.blanked) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected rgb565 %h blanked %b, %s %h blanked %b",
                       want.pixel_rgb565, want.blanked, "got rgb565",
                       rsp.pixel_rgb565, rsp.blanked);
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (req.op == pspm_pkg::OP_WRITE) begin
          if (int'(req.entry_index) < PALETTE_ENTRIES)
            palette_copy[req.entry_index] = req.entry_color;
        end else begin
          expected_pixels.push_back(predict_pixel(req));
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives palette writes, pixels and register settings into the pixel mapper
// with bursty input and a stalling output, and reports the verdict from the
// checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD  = 12;
  localparam int PAL_ENTRIES = 256;
  localparam int COL_COUNT   = 320;
  localparam int LINE_COUNT  = 240;
  localparam int LEFT        = 32;
  localparam int TOP         = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  pspm_pkg::req_t                  req       = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  pspm_pkg::rsp_t                  rsp;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pspm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pspm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int pending;
  int checked;

  int n_pixels;
  int n_writes;
  int n_settings;
  int burst_left;
  bit no_gaps;
  int cur_w = 256;
  int cur_h = 224;
  int cycles;

  bit hold_request;
  bit hold_taken;
  int hold_left;
  int rx_cycle;
  int rx_mode;

  always #(CLK_PERIOD / 2) clk = ~clk;

  palette_scanline_pixel_mapper #(
    .PALETTE_ENTRIES(PAL_ENTRIES),
    .LOGICAL_WIDTH  (COL_COUNT),
    .LOGICAL_LINES  (LINE_COUNT),
    .LEFT_BORDER    (LEFT),
    .TOP_BORDER     (TOP)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pixel_color_checker #(
    .PALETTE_ENTRIES(PAL_ENTRIES),
    .LOGICAL_WIDTH  (COL_COUNT),
    .LOGICAL_LINES  (LINE_COUNT),
    .LEFT_BORDER    (LEFT),
    .TOP_BORDER     (TOP)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending),
    .checked   (checked)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: stall pattern is redrawn at random from four modes; one long hold-off on request
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = int'($urandom_range(0, 3));
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = 300;
      rsp_stall <= 1'b1;
    end else begin
      unique case (rx_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= (rx_cycle % 3 == 0);
      endcase
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic offer(input pspm_pkg::req_t r);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (r.op == pspm_pkg::OP_PIXEL) n_pixels++;
    else n_writes++;
    @(negedge clk);
    if (no_gaps || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 80))
                                               : int'($urandom_range(0, 12));
    end
  endtask

  // Hold the input until every pixel result is back.
  task automatic settle();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_config(input bit g, input bit s, input bit src,
                              input int unsigned w, input int unsigned h);
    logic [pspm_pkg::CFG_IDX_W-1:0]  idxs [5];
    logic [pspm_pkg::CFG_DATA_W-1:0] vals [5];
    idxs[0] = pspm_pkg::CFG_GREYSCALE;     vals[0] = {8'd0, g};
    idxs[1] = pspm_pkg::CFG_SCANLINE;      vals[1] = {8'd0, s};
    idxs[2] = pspm_pkg::CFG_SOURCE;        vals[2] = {8'd0, src};
    idxs[3] = pspm_pkg::CFG_ACTIVE_WIDTH;  vals[3] = w[8:0];
    idxs[4] = pspm_pkg::CFG_ACTIVE_HEIGHT; vals[4] = {1'b0, h[7:0]};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_w = int'(w[8:0]);
    cur_h = int'(h[7:0]);
    n_settings++;
  endtask

  function automatic pspm_pkg::req_t pixel_at(int ln, int col, int idx);
    pspm_pkg::req_t r;
    r.op          = pspm_pkg::OP_PIXEL;
    r.entry_index = 8'($urandom);
    r.entry_color = 24'($urandom);
    r.line        = 8'(ln);
    r.column      = 9'(col);
    r.pixel_index = 8'(idx);
    return r;
  endfunction

  function automatic pspm_pkg::req_t palette_write(int idx, int color);
    pspm_pkg::req_t r;
    r             = pixel_at(int'($urandom), int'($urandom), int'($urandom));
    r.op          = pspm_pkg::OP_WRITE;
    r.entry_index = 8'(idx);
    r.entry_color = 24'(color);
    return r;
  endfunction

  // Mostly near the visible window edges, some anywhere in the field range
  function automatic pspm_pkg::req_t rand_pixel();
    int ln;
    int col;
    int idx;
    int w;
    w = (cur_w > COL_COUNT - LEFT) ? COL_COUNT - LEFT : cur_w;
    if ($urandom_range(0, 4) == 0) begin
      ln  = int'($urandom_range(0, 255));
      col = int'($urandom_range(0, 511));
    end else begin
      ln  = int'($urandom_range(TOP - 1, TOP + cur_h + 1));
      col = int'($urandom_range(LEFT - 2, LEFT + w + 1));
    end
    idx = $urandom_range(0, 1) ? int'($urandom_range(0, 15)) : int'($urandom_range(0, 255));
    return pixel_at(ln, col, idx);
  endfunction

  function automatic pspm_pkg::req_t rand_write();
    int idx;
    idx = $urandom_range(0, 1) ? int'($urandom_range(0, 15)) : int'($urandom_range(0, 255));
    return palette_write(idx, int'($urandom_range(0, 24'hffffff)));
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no source attached after reset
    offer(pixel_at(TOP, LEFT, 0));
    settle();
    apply_config(1'b0, 1'b0, 1'b1, 256, 224);
    offer(palette_write(0, 24'hffffff));
    offer(palette_write(255, 24'h123456));
    offer(palette_write(1, 24'hf80408));
    offer(palette_write(7, 24'ha5a5a5));
    offer(pixel_at(TOP, LEFT, 0));
    offer(pixel_at(TOP + 223, LEFT + 255, 255));
    offer(pixel_at(TOP - 1, LEFT, 0));
    offer(pixel_at(TOP + 224, LEFT, 0));
    offer(pixel_at(TOP, LEFT - 1, 0));
    offer(pixel_at(TOP, LEFT + 256, 0));
    offer(pixel_at(255, 511, 1));
    offer(pixel_at(LINE_COUNT - 1, COL_COUNT - 1, 1));
    offer(pixel_at(TOP + 1, 100, 3));   // never written: black, not blanked
    settle();
    // grey plus CRT lines, widest legal window
    apply_config(1'b1, 1'b1, 1'b1, 288, 232);
    offer(pixel_at(TOP, COL_COUNT - 1, 255));
    offer(pixel_at(TOP + 1, 40, 0));
    offer(pixel_at(TOP + 2, 40, 1));
    offer(pixel_at(TOP + 231, 40, 7));
    offer(pixel_at(LINE_COUNT, 40, 7));
    settle();
    // zero width blanks every column
    apply_config(1'b0, 1'b0, 1'b1, 0, 255);
    offer(pixel_at(TOP, LEFT, 0));
    offer(pixel_at(100, 50, 0));
    settle();
    // oversize width saturates at the right edge
    apply_config(1'b0, 1'b0, 1'b1, 511, 255);
    offer(pixel_at(TOP, COL_COUNT - 1, 0));
    offer(pixel_at(TOP, COL_COUNT, 0));
    offer(pixel_at(LINE_COUNT - 2, COL_COUNT - 1, 255));
    settle();

    // back-pressure: output held off while input keeps coming
    apply_config(1'b0, 1'b0, 1'b1, 256, 224);
    no_gaps      = 1'b1;
    hold_request = 1'b1;
    repeat (60) offer(rand_pixel());
    no_gaps = 1'b0;
    settle();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: apply_config(1'($urandom), 1'($urandom), 1'b1, 1, 1);
        1: apply_config(1'($urandom), 1'($urandom), 1'b1, 288, 232);
        2: apply_config(1'($urandom), 1'($urandom), 1'b1, 511, 255);
        3: apply_config(1'($urandom), 1'($urandom), 1'b1, 0, 0);
        4: apply_config(1'($urandom), 1'($urandom), 1'b0, 256, 224);
        default: apply_config(1'($urandom), 1'($urandom), $urandom_range(0, 4) != 0,
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                          : $urandom_range(1, 288),
                              $urandom_range(0, 232));
      endcase
      repeat (48) offer(($urandom_range(0, 3) == 0) ? rand_write() : rand_pixel());
      settle();
    end

    repeat (6) @(negedge clk);
    $display("covered %0d pixels and %0d palette writes over %0d register settings",
             n_pixels, n_writes, n_settings);
    $display("%0d results checked, %0d mismatches", checked, mismatches);
    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
